// ===== src/hsv2rgb_pkg.sv =====
// shared constants, payload structs and sector codes for the hsv to rgb pipeline
// no dependencies; used by every module of the converter
package hsv2rgb_pkg;

	// fixed-point formats: hue carries FRAC_BITS fraction bits per sector, s and v are Q(FRAC_BITS)
	localparam int FRAC_BITS = 12;
	localparam int HUE_W     = 15;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int SEC_W     = HUE_W - FRAC_BITS;
	localparam int PROD_W    = 2 * FRAC_BITS + 1;
	localparam int X_W       = 3 * FRAC_BITS + 1;
	localparam int CH_W      = 8;
	localparam int SCALED_W  = X_W + CH_W;

	localparam logic [Q_W-1:0]    ONE    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PROD_W-1:0] ONE_SQ = {1'b1, {(2 * FRAC_BITS){1'b0}}};

	// hue sectors; sector five, exactly 360 degrees and above share the default routing
	localparam logic [SEC_W-1:0] SEC_RED_YEL = SEC_W'(0);
	localparam logic [SEC_W-1:0] SEC_YEL_GRN = SEC_W'(1);
	localparam logic [SEC_W-1:0] SEC_GRN_CYN = SEC_W'(2);
	localparam logic [SEC_W-1:0] SEC_CYN_BLU = SEC_W'(3);
	localparam logic [SEC_W-1:0] SEC_BLU_MAG = SEC_W'(4);

	// stage 1 payload: clamped value, saturation products
	typedef struct packed {
		logic [SEC_W-1:0]  sector;
		logic [Q_W-1:0]    val;
		logic [Q_W-1:0]    inv_sat;
		logic [PROD_W-1:0] sat_f;
		logic [PROD_W-1:0] sat_fc;
	} prod_t;

	// stage 2 payload: v, p, q, t with 3*FRAC_BITS fraction bits
	typedef struct packed {
		logic [SEC_W-1:0] sector;
		logic [X_W-1:0]   vv;
		logic [X_W-1:0]   p;
		logic [X_W-1:0]   q;
		logic [X_W-1:0]   t;
	} term_t;

	// stage 3 payload: final 8-bit channels
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

endpackage

// ===== src/hsv2rgb_prod.sv =====
// stage 1: clamps saturation and value, splits hue, forms saturation products
// depends on hsv2rgb_pkg
module hsv2rgb_prod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
	input  logic [hsv2rgb_pkg::Q_W-1:0]       saturation,
	input  logic [hsv2rgb_pkg::Q_W-1:0]       brightness,
	output logic                              out_valid,
	input  logic                              out_ready,
	output hsv2rgb_pkg::prod_t                out_data
);

	logic [hsv2rgb_pkg::Q_W-1:0]       sat_c;
	logic [hsv2rgb_pkg::Q_W-1:0]       val_c;
	logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac;
	logic [hsv2rgb_pkg::Q_W-1:0]       frac_c;
	hsv2rgb_pkg::prod_t                next_d;
	logic                              valid_s1;
	hsv2rgb_pkg::prod_t                data_s1;

	// clamp to one and form s*f, s*(1-f)
	always_comb begin
		sat_c  = (saturation > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : saturation;
		val_c  = (brightness > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : brightness;
		frac   = hue[hsv2rgb_pkg::FRAC_BITS-1:0];
		frac_c = hsv2rgb_pkg::ONE - {1'b0, frac};
		next_d.sector  = hue[hsv2rgb_pkg::HUE_W-1:hsv2rgb_pkg::FRAC_BITS];
		next_d.val     = val_c;
		next_d.inv_sat = hsv2rgb_pkg::ONE - sat_c;
		next_d.sat_f   = hsv2rgb_pkg::PROD_W'(sat_c) * hsv2rgb_pkg::PROD_W'(frac);
		next_d.sat_fc  = hsv2rgb_pkg::PROD_W'(sat_c) * hsv2rgb_pkg::PROD_W'(frac_c);
	end

	// stage moves when empty or when downstream takes its item
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= next_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

`ifndef ASSERT_OFF
	// a held item stays put while downstream is full
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(data_s1))
		else $error("stage 1 item changed while held");
`endif

endmodule

// ===== src/hsv2rgb_scale.sv =====
// stage 2: multiplies value into p, q, t and v at full precision
// depends on hsv2rgb_pkg
module hsv2rgb_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsv2rgb_pkg::prod_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsv2rgb_pkg::term_t out_data
);

	logic [hsv2rgb_pkg::PROD_W-1:0] q_fac;
	logic [hsv2rgb_pkg::PROD_W-1:0] t_fac;
	logic [hsv2rgb_pkg::X_W-1:0]    p_raw;
	hsv2rgb_pkg::term_t             next_d;
	logic                           valid_s2;
	hsv2rgb_pkg::term_t             data_s2;

	// p = v(1-s), q = v(1-sf), t = v(1-s(1-f)), all at 3*FRAC_BITS fraction bits
	always_comb begin
		q_fac = hsv2rgb_pkg::ONE_SQ - in_data.sat_f;
		t_fac = hsv2rgb_pkg::ONE_SQ - in_data.sat_fc;
		p_raw = hsv2rgb_pkg::X_W'(in_data.val) * hsv2rgb_pkg::X_W'(in_data.inv_sat);
		next_d.sector = in_data.sector;
		next_d.vv     = hsv2rgb_pkg::X_W'(in_data.val) << (2 * hsv2rgb_pkg::FRAC_BITS);
		next_d.p      = p_raw << hsv2rgb_pkg::FRAC_BITS;
		next_d.q      = hsv2rgb_pkg::X_W'(in_data.val) * hsv2rgb_pkg::X_W'(q_fac);
		next_d.t      = hsv2rgb_pkg::X_W'(in_data.val) * hsv2rgb_pkg::X_W'(t_fac);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= next_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

`ifndef ASSERT_OFF
	// with saturation clamped to one, p is the floor and v the ceiling
	a_order_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (data_s2.p <= data_s2.q) && (data_s2.p <= data_s2.t) &&
			(data_s2.q <= data_s2.vv) && (data_s2.t <= data_s2.vv))
		else $error("stage 2 terms out of order");
`endif

endmodule

// ===== src/hsv2rgb_route.sv =====
// stage 3: routes v, p, q, t to channels by sector and scales by 255
// depends on hsv2rgb_pkg
module hsv2rgb_route (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsv2rgb_pkg::term_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::pixel_t out_data
);

	logic [hsv2rgb_pkg::X_W-1:0] r_x;
	logic [hsv2rgb_pkg::X_W-1:0] g_x;
	logic [hsv2rgb_pkg::X_W-1:0] b_x;
	hsv2rgb_pkg::pixel_t         next_d;
	logic                        valid_s3;
	hsv2rgb_pkg::pixel_t         data_s3;

	// 255*x as (x<<8)-x, then drop the fraction bits
	function automatic logic [hsv2rgb_pkg::CH_W-1:0] to_channel(
		input logic [hsv2rgb_pkg::X_W-1:0] x);
		logic [hsv2rgb_pkg::SCALED_W-1:0] wide;
		wide = (hsv2rgb_pkg::SCALED_W'(x) << hsv2rgb_pkg::CH_W) - hsv2rgb_pkg::SCALED_W'(x);
		return wide[3 * hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::CH_W];
	endfunction

	// sector routing
	always_comb begin
		case (in_data.sector)
			hsv2rgb_pkg::SEC_RED_YEL: begin
				r_x = in_data.vv; g_x = in_data.t;  b_x = in_data.p;
			end
			hsv2rgb_pkg::SEC_YEL_GRN: begin
				r_x = in_data.q;  g_x = in_data.vv; b_x = in_data.p;
			end
			hsv2rgb_pkg::SEC_GRN_CYN: begin
				r_x = in_data.p;  g_x = in_data.vv; b_x = in_data.t;
			end
			hsv2rgb_pkg::SEC_CYN_BLU: begin
				r_x = in_data.p;  g_x = in_data.q;  b_x = in_data.vv;
			end
			hsv2rgb_pkg::SEC_BLU_MAG: begin
				r_x = in_data.t;  g_x = in_data.p;  b_x = in_data.vv;
			end
			default: begin
				r_x = in_data.vv; g_x = in_data.p;  b_x = in_data.q;
			end
		endcase
		next_d.red   = to_channel(r_x);
		next_d.green = to_channel(g_x);
		next_d.blue  = to_channel(b_x);
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= next_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

`ifndef ASSERT_OFF
	// an item taken from stage 2 always shows up at the output register
	a_adv_s3: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s3)
		else $error("item lost entering output stage");
`endif

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// top level of the hsv to rgb converter: three pipeline stages
// depends on hsv2rgb_pkg, hsv2rgb_prod, hsv2rgb_scale, hsv2rgb_route
//
// usage:
// - input channel: in_valid / in_stall with hue, saturation, brightness;
//   an item is taken at a clock edge with in_valid high and in_stall low
// - output channel: out_valid / out_stall with red, green, blue;
//   a result is taken at a clock edge with out_valid high and out_stall low
// - each item passes through one register per stage: saturation products, value
//   multiplies, sector routing with 255 scaling
// - throughput: one item per clock, limited only by the receiver
// - saturation and brightness above 1.0 are clamped; hue sectors from 360
//   degrees upward use the same routing as sector five
// - reset (arst_n low) empties the pipeline at once; no item is in flight after it
// - when the receiver stalls, the output holds its result and each stage
//   holds its item; in_stall rises only once every stage is full
module hsv_to_rgb_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
	input  logic [hsv2rgb_pkg::Q_W-1:0]         saturation,
	input  logic [hsv2rgb_pkg::Q_W-1:0]         brightness,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hsv2rgb_pkg::CH_W-1:0]        red,
	output logic [hsv2rgb_pkg::CH_W-1:0]        green,
	output logic [hsv2rgb_pkg::CH_W-1:0]        blue
);

	logic                in_ready;
	logic                valid_1;
	logic                ready_1;
	hsv2rgb_pkg::prod_t  data_1;
	logic                valid_2;
	logic                ready_2;
	hsv2rgb_pkg::term_t  data_2;
	hsv2rgb_pkg::pixel_t pix;

	// stage 1
	hsv2rgb_prod u_prod (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (valid_1),
		.out_ready  (ready_1),
		.out_data   (data_1)
	);

	// stage 2
	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_1),
		.in_ready  (ready_1),
		.in_data   (data_1),
		.out_valid (valid_2),
		.out_ready (ready_2),
		.out_data  (data_2)
	);

	// stage 3, doubles as output register
	hsv2rgb_route u_route (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_2),
		.in_ready  (ready_2),
		.in_data   (data_2),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.out_data  (pix)
	);

	assign in_stall = !in_ready;
	assign red      = pix.red;
	assign green    = pix.green;
	assign blue     = pix.blue;

endmodule
